// File: design/setu_pkg.sv
// ----------------------------------------------------------------------------
// setu_pkg: shared types and constants of the soft envelope tracker
// Beat layouts, register map, controller states, serial multiplier
// handshake and the fixed-point helper functions.
// ----------------------------------------------------------------------------
package setu_pkg;

  // Number formats
  localparam int SampleW  = 16;                  // input sample width
  localparam int FracW    = 16;                  // fraction bits of the bounds
  localparam int BoundW   = SampleW + FracW;     // bound width, Q16.16
  localparam int ExtW     = BoundW + 2;          // headroom for add, subtract
  localparam int PosW     = FracW + 1;           // position, Q0.16 up to 1.0
  localparam int CfgW     = 32;                  // register data width
  localparam int AddrW    = 5;                   // byte address of seven words
  localparam int RegIdxW  = AddrW - 2;

  // Serial multiplier: two factor bits per cycle
  localparam int MulSteps = (FracW + 1) / 2;
  localparam int MulFacW  = 2 * MulSteps;
  localparam int MulCntW  = $clog2(MulSteps + 2);

  // Serial divider: one quotient bit per cycle
  localparam int DivCntW  = $clog2(FracW + 1);

  localparam logic [PosW-1:0] PosOne = {1'b1, {FracW{1'b0}}};

  // Register map, one 32-bit word each
  typedef enum logic [RegIdxW-1:0] {
    RegDecayAmount  = 3'd0,
    RegGrowthAmount = 3'd1,
    RegDecayExp     = 3'd2,
    RegGrowthExp    = 3'd3,
    RegPresetEnable = 3'd4,
    RegPresetLower  = 3'd5,
    RegPresetUpper  = 3'd6
  } setu_reg_e;

  // Controller states
  typedef enum logic [3:0] {
    StIdle,
    StUpdate,
    StGrowMul,
    StDecay,
    StDecayMul,
    StSpan,
    StCompare,
    StDivide,
    StDone
  } setu_state_e;

  // Input beat
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      restart;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic signed [BoundW-1:0] upper_out;
    logic signed [BoundW-1:0] lower_out;
    logic        [BoundW-1:0] span;
    logic        [PosW-1:0]   position;
    logic                     ready_res;
  } out_beat_t;

  // Serial multiplier request and response
  typedef struct packed {
    logic              start;
    logic [BoundW-1:0] mag;
    logic [FracW-1:0]  factor;
  } smul_req_t;

  typedef struct packed {
    logic              done;
    logic [BoundW-1:0] prod;
  } smul_rsp_t;

  // Shrink factor max(0, 1 - amount); only used with a nonzero amount
  function automatic logic [FracW-1:0] factor_of(input logic [CfgW-1:0] amount);
    logic [FracW-1:0] low;
    low = amount[FracW-1:0];
    if (amount[CfgW-1:FracW] != '0) begin
      return '0;
    end
    return ~low + FracW'(1);
  endfunction

  // Integer sample to Q16.16
  function automatic logic signed [BoundW-1:0] to_fixed(
    input logic signed [SampleW-1:0] s
  );
    return {s, {FracW{1'b0}}};
  endfunction

endpackage

// File: design/setu_smul.sv
// ----------------------------------------------------------------------------
// setu_smul: radix-4 serial multiplier
// Multiplies an unsigned magnitude by a Q0.16 factor two factor bits per
// cycle and returns the product shifted down by the fraction bits.
// ----------------------------------------------------------------------------
module setu_smul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  setu_pkg::smul_req_t  req_i,
  output setu_pkg::smul_rsp_t  rsp_o
);

  localparam int BW = setu_pkg::BoundW;
  localparam int FW = setu_pkg::MulFacW;
  localparam int CW = setu_pkg::MulCntW;

  localparam logic [CW-1:0] CntSetup = CW'(setu_pkg::MulSteps + 1);
  localparam logic [CW-1:0] CntLast  = CW'(1);

  logic [CW-1:0]   cnt_q, cnt_d;
  logic            done_q;
  logic [BW-1:0]   mag_q, mag_d;
  logic [BW+1:0]   m3_q, m3_d;
  logic [FW-1:0]   fac_q, fac_d;
  logic [BW-1:0]   hi_q, hi_d;
  logic [FW-1:0]   lo_q, lo_d;
  logic [BW+1:0]   addend;
  logic [BW+1:0]   sum;
  logic [BW+FW-1:0] full_prod;

  // Partial product for the current digit
  always_comb begin
    case (fac_q[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = (BW+2)'(mag_q);
      2'd2:    addend = (BW+2)'({mag_q, 1'b0});
      default: addend = m3_q;
    endcase
  end

  assign sum = (BW+2)'(hi_q) + addend;

  // Load, triple-multiple setup, then one digit per cycle
  always_comb begin
    cnt_d = cnt_q;
    mag_d = mag_q;
    m3_d  = m3_q;
    fac_d = fac_q;
    hi_d  = hi_q;
    lo_d  = lo_q;
    if (req_i.start) begin
      cnt_d = CntSetup;
      mag_d = req_i.mag;
      fac_d = FW'(req_i.factor);
      hi_d  = '0;
      lo_d  = '0;
    end else if (cnt_q == CntSetup) begin
      m3_d  = (BW+2)'(mag_q) + (BW+2)'({mag_q, 1'b0});
      cnt_d = cnt_q - CW'(1);
    end else if (cnt_q != '0) begin
      hi_d  = sum[BW+1:2];
      lo_d  = {sum[1:0], lo_q[FW-1:2]};
      fac_d = {2'b00, fac_q[FW-1:2]};
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= !req_i.start && (cnt_q == CntLast);
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    m3_q  <= m3_d;
    fac_q <= fac_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
  end

  assign full_prod  = {hi_q, lo_q};
  assign rsp_o.done = done_q;
  assign rsp_o.prod = full_prod[setu_pkg::FracW +: BW];

endmodule

// File: design/soft_envelope_tracker_unit.sv
// ----------------------------------------------------------------------------
// soft_envelope_tracker_unit: soft upper/lower envelope of a sample stream
// Tracks Q16.16 bounds with growth and decay, reports bounds, span and the
// normalized position of the last sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (sample, restart) arrive on in_valid_i/in_ready_o; one result
//   beat per input leaves on out_valid_o/out_ready_i through an output
//   register. The block works on one beat at a time: in_ready_o is high only
//   while the controller waits for work.
//   A restart or a first sample goes from accept straight to the span and
//   position states; an update with exponential growth and decay and a
//   full division also runs the two radix-4 serial multipliers (one growth
//   pass, one decay pass) and the position divider, which produces one
//   quotient bit per cycle.
//   A finished result waits in the output register; the next input beat is
//   accepted meanwhile, and only the write of the following result waits for
//   the receiver.
//   Reset clears the bounds (not initialized) and loads the register reset
//   values; the preset bounds are loaded only by a restart beat.
//   Registers sit on an APB-style port at byte offsets 4*index, pready tied
//   high; write them only while the block is idle.
// ----------------------------------------------------------------------------
module soft_envelope_tracker_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  setu_pkg::in_beat_t              in_data_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output setu_pkg::out_beat_t             out_data_o,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [setu_pkg::AddrW-1:0]      paddr,
  input  logic [setu_pkg::CfgW-1:0]       pwdata,
  output logic [setu_pkg::CfgW-1:0]       prdata,
  output logic                            pready
);

  localparam int SW  = setu_pkg::SampleW;
  localparam int FB  = setu_pkg::FracW;
  localparam int BW  = setu_pkg::BoundW;
  localparam int XW  = setu_pkg::ExtW;
  localparam int PW  = setu_pkg::PosW;
  localparam int CW  = setu_pkg::CfgW;
  localparam int DCW = setu_pkg::DivCntW;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [CW-1:0]          decay_amt_q, growth_amt_q;
  logic                   decay_exp_q, growth_exp_q, preset_en_q;
  logic signed [SW-1:0]   preset_lo_q, preset_hi_q;
  logic                   cfg_wr;
  logic [setu_pkg::RegIdxW-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[setu_pkg::AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_amt_q  <= '0;
      growth_amt_q <= '0;
      decay_exp_q  <= 1'b1;
      growth_exp_q <= 1'b1;
      preset_en_q  <= 1'b0;
      preset_lo_q  <= '0;
      preset_hi_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        setu_pkg::RegDecayAmount:  decay_amt_q  <= pwdata;
        setu_pkg::RegGrowthAmount: growth_amt_q <= pwdata;
        setu_pkg::RegDecayExp:     decay_exp_q  <= pwdata[0];
        setu_pkg::RegGrowthExp:    growth_exp_q <= pwdata[0];
        setu_pkg::RegPresetEnable: preset_en_q  <= pwdata[0];
        setu_pkg::RegPresetLower:  preset_lo_q  <= pwdata[SW-1:0];
        setu_pkg::RegPresetUpper:  preset_hi_q  <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      setu_pkg::RegDecayAmount:  prdata = decay_amt_q;
      setu_pkg::RegGrowthAmount: prdata = growth_amt_q;
      setu_pkg::RegDecayExp:     prdata = CW'(decay_exp_q);
      setu_pkg::RegGrowthExp:    prdata = CW'(growth_exp_q);
      setu_pkg::RegPresetEnable: prdata = CW'(preset_en_q);
      setu_pkg::RegPresetLower:  prdata = CW'(unsigned'(preset_lo_q));
      setu_pkg::RegPresetUpper:  prdata = CW'(unsigned'(preset_hi_q));
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  setu_pkg::setu_state_e state_q, state_d;

  logic signed [BW-1:0]  upper_q, upper_d, lower_q, lower_d;
  logic signed [SW-1:0]  last_q, last_d;
  logic                  init_q, init_d;

  logic signed [SW-1:0]  samp_q, samp_d;
  logic                  restart_q, restart_d;
  logic                  side_lo_q, side_lo_d;
  logic                  neg_a_q, neg_a_d, neg_b_q, neg_b_d;
  logic [BW-1:0]         span_q, span_d;
  logic signed [XW-1:0]  diff_q, diff_d;
  logic [BW-1:0]         rem_q, rem_d;
  logic [FB-1:0]         quo_q, quo_d;
  logic [DCW-1:0]        dcnt_q, dcnt_d;
  logic [PW-1:0]         pos_q, pos_d;

  logic                  out_valid_q;
  setu_pkg::out_beat_t   out_q, out_d;
  logic                  out_load;

  // Serial multipliers: unit a handles growth and the upper decay, unit b
  // the lower decay
  setu_pkg::smul_req_t   req_a, req_b;
  setu_pkg::smul_rsp_t   rsp_a, rsp_b;

  setu_smul u_mul_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_a),
    .rsp_o  (rsp_a)
  );

  setu_smul u_mul_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_b),
    .rsp_o  (rsp_b)
  );

  // --------------------------------------------------------------------------
  // Shared arithmetic
  // --------------------------------------------------------------------------
  logic signed [BW-1:0] v_fx;
  logic signed [XW-1:0] v_x, up_x, lo_x, ga_x, da_x, last_x;
  logic signed [XW-1:0] d_up, d_lo;
  logic                 neg_up, neg_lo;
  logic [BW-1:0]        mag_up, mag_lo;
  logic                 above, below;
  logic signed [XW-1:0] grow_up_lin, grow_lo_lin, dec_up_lin, dec_lo_lin;
  logic signed [XW-1:0] res_a, res_b;
  logic [FB-1:0]        grow_fac, decay_fac;
  logic                 grow_on, decay_on, grow_mul;
  logic signed [SW-1:0] pre_lo, pre_hi;
  logic [BW:0]          rem_dbl;
  logic                 rem_ge;

  assign v_fx   = setu_pkg::to_fixed(samp_q);
  assign v_x    = XW'(v_fx);
  assign up_x   = XW'(upper_q);
  assign lo_x   = XW'(lower_q);
  assign ga_x   = signed'(XW'(growth_amt_q));
  assign da_x   = signed'(XW'(decay_amt_q));
  assign last_x = XW'(setu_pkg::to_fixed(last_q));

  // Gap magnitudes to the sample
  assign d_up   = up_x - v_x;
  assign d_lo   = lo_x - v_x;
  assign neg_up = d_up[XW-1];
  assign neg_lo = d_lo[XW-1];
  assign mag_up = BW'(neg_up ? -d_up : d_up);
  assign mag_lo = BW'(neg_lo ? -d_lo : d_lo);

  assign above  = v_x > up_x;
  assign below  = v_x < lo_x;

  // Linear steps
  assign grow_up_lin = up_x + ga_x;
  assign grow_lo_lin = lo_x - ga_x;
  assign dec_up_lin  = up_x - da_x;
  assign dec_lo_lin  = lo_x + da_x;

  // Shrunk gaps from the multipliers
  assign res_a = neg_a_q ? v_x - signed'(XW'(rsp_a.prod)) : v_x + signed'(XW'(rsp_a.prod));
  assign res_b = neg_b_q ? v_x - signed'(XW'(rsp_b.prod)) : v_x + signed'(XW'(rsp_b.prod));

  assign grow_fac  = setu_pkg::factor_of(growth_amt_q);
  assign decay_fac = setu_pkg::factor_of(decay_amt_q);
  assign grow_on   = growth_amt_q != '0;
  assign decay_on  = decay_amt_q != '0;
  assign grow_mul  = grow_on && growth_exp_q && (above || below);

  // Ordered preset bounds
  assign pre_lo = (preset_lo_q > preset_hi_q) ? preset_hi_q : preset_lo_q;
  assign pre_hi = (preset_lo_q > preset_hi_q) ? preset_lo_q : preset_hi_q;

  // Restoring division step
  assign rem_dbl = {rem_q, 1'b0};
  assign rem_ge  = rem_dbl >= {1'b0, span_q};

  assign out_load = !out_valid_q || out_ready_i;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      setu_pkg::StIdle: begin
        if (in_valid_i) state_d = setu_pkg::StUpdate;
      end
      setu_pkg::StUpdate: begin
        if (restart_q || !init_q) state_d = setu_pkg::StSpan;
        else if (grow_mul)        state_d = setu_pkg::StGrowMul;
        else                      state_d = setu_pkg::StDecay;
      end
      setu_pkg::StGrowMul: begin
        if (rsp_a.done) state_d = setu_pkg::StDecay;
      end
      setu_pkg::StDecay: begin
        if (decay_on && decay_exp_q) state_d = setu_pkg::StDecayMul;
        else                         state_d = setu_pkg::StSpan;
      end
      setu_pkg::StDecayMul: begin
        if (rsp_a.done) state_d = setu_pkg::StSpan;
      end
      setu_pkg::StSpan: begin
        state_d = setu_pkg::StCompare;
      end
      setu_pkg::StCompare: begin
        if (!init_q || span_q == '0 || diff_q <= 0 ||
            diff_q >= signed'(XW'(span_q))) begin
          state_d = setu_pkg::StDone;
        end else begin
          state_d = setu_pkg::StDivide;
        end
      end
      setu_pkg::StDivide: begin
        if (dcnt_q == DCW'(1)) state_d = setu_pkg::StDone;
      end
      setu_pkg::StDone: begin
        if (out_load) state_d = setu_pkg::StIdle;
      end
      default: state_d = setu_pkg::StIdle;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs per state
  // --------------------------------------------------------------------------
  always_comb begin
    upper_d   = upper_q;
    lower_d   = lower_q;
    last_d    = last_q;
    init_d    = init_q;
    samp_d    = samp_q;
    restart_d = restart_q;
    side_lo_d = side_lo_q;
    neg_a_d   = neg_a_q;
    neg_b_d   = neg_b_q;
    span_d    = span_q;
    diff_d    = diff_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dcnt_d    = dcnt_q;
    pos_d     = pos_q;
    out_d     = out_q;
    req_a     = '0;
    req_b     = '0;
    in_ready_o = 1'b0;

    case (state_q)
      setu_pkg::StIdle: begin
        in_ready_o = 1'b1;
        samp_d     = in_data_i.sample;
        restart_d  = in_data_i.restart;
      end

      // Restart, seed, or growth toward a new extreme
      setu_pkg::StUpdate: begin
        if (restart_q) begin
          if (preset_en_q) begin
            lower_d = setu_pkg::to_fixed(pre_lo);
            upper_d = setu_pkg::to_fixed(pre_hi);
            last_d  = pre_lo;
            init_d  = 1'b1;
          end else begin
            lower_d = '0;
            upper_d = '0;
            last_d  = '0;
            init_d  = 1'b0;
          end
        end else if (!init_q) begin
          lower_d = v_fx;
          upper_d = v_fx;
          last_d  = samp_q;
          init_d  = 1'b1;
        end else begin
          last_d = samp_q;
          if (grow_mul) begin
            req_a.start  = 1'b1;
            req_a.factor = grow_fac;
            side_lo_d    = !above;
            neg_a_d      = above ? neg_up : neg_lo;
            req_a.mag    = above ? mag_up : mag_lo;
          end else if (grow_on) begin
            if (above) upper_d = BW'((grow_up_lin > v_x) ? v_x : grow_up_lin);
            if (below) lower_d = BW'((grow_lo_lin < v_x) ? v_x : grow_lo_lin);
          end
        end
      end

      setu_pkg::StGrowMul: begin
        if (rsp_a.done) begin
          if (side_lo_q) lower_d = BW'(res_a);
          else           upper_d = BW'(res_a);
        end
      end

      // Decay both bounds toward the sample, never crossing it
      setu_pkg::StDecay: begin
        if (decay_on && decay_exp_q) begin
          req_a.start  = 1'b1;
          req_a.mag    = mag_up;
          req_a.factor = decay_fac;
          req_b.start  = 1'b1;
          req_b.mag    = mag_lo;
          req_b.factor = decay_fac;
          neg_a_d      = neg_up;
          neg_b_d      = neg_lo;
        end else if (decay_on) begin
          upper_d = BW'((dec_up_lin < v_x) ? v_x : dec_up_lin);
          lower_d = BW'((dec_lo_lin > v_x) ? v_x : dec_lo_lin);
        end
      end

      setu_pkg::StDecayMul: begin
        if (rsp_a.done) begin
          upper_d = BW'((res_a < v_x) ? v_x : res_a);
          lower_d = BW'((res_b > v_x) ? v_x : res_b);
        end
      end

      setu_pkg::StSpan: begin
        span_d = BW'(up_x - lo_x);
        diff_d = last_x - lo_x;
      end

      // Trivial positions, else start the divider
      setu_pkg::StCompare: begin
        pos_d  = '0;
        rem_d  = BW'(diff_q);
        quo_d  = '0;
        dcnt_d = DCW'(FB);
        if (init_q && span_q != '0 && diff_q > 0 &&
            diff_q >= signed'(XW'(span_q))) begin
          pos_d = setu_pkg::PosOne;
        end
      end

      setu_pkg::StDivide: begin
        rem_d  = rem_ge ? BW'(rem_dbl - {1'b0, span_q}) : BW'(rem_dbl);
        quo_d  = {quo_q[FB-2:0], rem_ge};
        dcnt_d = dcnt_q - DCW'(1);
        pos_d  = PW'(quo_d);
      end

      // Result goes out only once the output register is free
      setu_pkg::StDone: begin
        if (out_load) begin
          out_d.upper_out = init_q ? upper_q : '0;
          out_d.lower_out = init_q ? lower_q : '0;
          out_d.span      = init_q ? span_q : '0;
          out_d.position  = init_q ? pos_q : '0;
          out_d.ready_res = init_q;
        end
      end

      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= setu_pkg::StIdle;
      upper_q     <= '0;
      lower_q     <= '0;
      last_q      <= '0;
      init_q      <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      upper_q <= upper_d;
      lower_q <= lower_d;
      last_q  <= last_d;
      init_q  <= init_d;
      dcnt_q  <= dcnt_d;
      if (state_q == setu_pkg::StDone && out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    samp_q    <= samp_d;
    restart_q <= restart_d;
    side_lo_q <= side_lo_d;
    neg_a_q   <= neg_a_d;
    neg_b_q   <= neg_b_d;
    span_q    <= span_d;
    diff_q    <= diff_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    pos_q     <= pos_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Bounds stay ordered
  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lower_q <= upper_q)
    else $error("lower bound above upper bound");

  // Position never exceeds one
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.position <= setu_pkg::PosOne)
    else $error("position above one");

  // Uninitialized result carries zeros
  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ready_res |->
      out_data_o.upper_out == '0 && out_data_o.lower_out == '0 &&
      out_data_o.span == '0 && out_data_o.position == '0)
    else $error("uninitialized result not zero");

  // Both decay multipliers finish together
  a_decay_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == setu_pkg::StDecayMul |-> rsp_a.done == rsp_b.done)
    else $error("decay multipliers out of step");

  // A result is only written when the output register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == setu_pkg::StDone && out_valid_q && !out_ready_i |=>
      state_q == setu_pkg::StDone)
    else $error("pending result overwritten");

endmodule
